// File: rtl/hdas_pkg.sv
package hdas_pkg;

    // Width of one stored word and of the hash.
    localparam int unsigned WORD_W    = 32;
    // The modulo unit retires two dividend bits per cycle.
    localparam int unsigned DIV_STEPS = WORD_W / 2;
    localparam int unsigned PH_W      = $clog2(DIV_STEPS);

    // Hash unit operation codes.
    localparam logic [2:0] HOP_NONE = 3'd0;
    localparam logic [2:0] HOP_BYTE = 3'd1;
    localparam logic [2:0] HOP_FIN0 = 3'd2;
    localparam logic [2:0] HOP_FIN1 = 3'd3;
    localparam logic [2:0] HOP_FIN2 = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_wr;
        logic       seed_init;
        logic [2:0] hop;
        logic [1:0] byte_sel;
        logic       div_start;
        logic       div_step;
        logic       seed_from_rem;
        logic       rd_seed;
        logic       tmp_load;
        logic       wr_idx;
        logic       wr_seed;
        logic       idx_clr;
        logic       idx_inc;
        logic       out_load;
        logic       count_clr;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_pos;
    } sts_t;

endpackage

// File: rtl/hdas_ctrl.sv
module hdas_ctrl
    import hdas_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    input  logic s_tlast,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_SEED  = 4'd1;
    localparam logic [3:0] ST_HBYTE = 4'd2;
    localparam logic [3:0] ST_HFIN0 = 4'd3;
    localparam logic [3:0] ST_HFIN1 = 4'd4;
    localparam logic [3:0] ST_HFIN2 = 4'd5;
    localparam logic [3:0] ST_DIVST = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_SW0   = 4'd8;
    localparam logic [3:0] ST_SW1   = 4'd9;
    localparam logic [3:0] ST_SW2   = 4'd10;
    localparam logic [3:0] ST_SW3   = 4'd11;
    localparam logic [3:0] ST_E0    = 4'd12;
    localparam logic [3:0] ST_E1    = 4'd13;
    localparam logic [3:0] ST_E2    = 4'd14;

    localparam logic [PH_W-1:0] PH_BYTE_LAST = PH_W'(3);
    localparam logic [PH_W-1:0] PH_DIV_LAST  = PH_W'(DIV_STEPS - 1);

    logic [3:0]      state_reg, state_next;
    logic [PH_W-1:0] ph_reg, ph_next;

    // State and phase counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            ph_reg    <= '0;
        end else begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
        end
    end

    // Next state and command decode.
    always_comb begin
        state_next   = state_reg;
        ph_next      = ph_reg;
        cmd          = '0;
        cmd.hop      = HOP_NONE;
        cmd.byte_sel = ph_reg[1:0];
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_wr = 1'b1;
                    if (s_tlast) begin
                        state_next = ST_SEED;
                    end
                end
            end
            ST_SEED: begin
                cmd.seed_init = 1'b1;
                cmd.idx_clr   = 1'b1;
                ph_next       = '0;
                state_next    = ST_HBYTE;
            end
            ST_HBYTE: begin
                cmd.hop = HOP_BYTE;
                if (ph_reg == PH_BYTE_LAST) begin
                    ph_next    = '0;
                    state_next = ST_HFIN0;
                end else begin
                    ph_next = ph_reg + 1'b1;
                end
            end
            ST_HFIN0: begin
                cmd.hop    = HOP_FIN0;
                state_next = ST_HFIN1;
            end
            ST_HFIN1: begin
                cmd.hop    = HOP_FIN1;
                state_next = ST_HFIN2;
            end
            ST_HFIN2: begin
                cmd.hop    = HOP_FIN2;
                state_next = ST_DIVST;
            end
            ST_DIVST: begin
                cmd.div_start = 1'b1;
                ph_next       = '0;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (ph_reg == PH_DIV_LAST) begin
                    ph_next    = '0;
                    state_next = ST_SW0;
                end else begin
                    ph_next = ph_reg + 1'b1;
                end
            end
            ST_SW0: begin
                // New seed is taken and element i is read.
                cmd.seed_from_rem = 1'b1;
                state_next        = ST_SW1;
            end
            ST_SW1: begin
                cmd.rd_seed  = 1'b1;
                cmd.tmp_load = 1'b1;
                state_next   = ST_SW2;
            end
            ST_SW2: begin
                cmd.wr_idx = 1'b1;
                state_next = ST_SW3;
            end
            ST_SW3: begin
                cmd.wr_seed = 1'b1;
                if (sts.last_pos) begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_E0;
                end else begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_HBYTE;
                end
            end
            ST_E0: begin
                state_next = ST_E1;
            end
            ST_E1: begin
                cmd.out_load = 1'b1;
                state_next   = ST_E2;
            end
            ST_E2: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (sts.last_pos) begin
                        cmd.count_clr = 1'b1;
                        state_next    = ST_LOAD;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_E0;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// File: rtl/hdas_dp.sv
module hdas_dp
    import hdas_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    input  logic [WORD_W-1:0] in_value,
    output sts_t              sts,
    output logic [WORD_W-1:0] out_value,
    output logic              out_last
);

    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned RW    = CNT_W + 1;

    logic [WORD_W-1:0] store_mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [WORD_W-1:0] seed_reg, seed_next;
    logic [WORD_W-1:0] hash_reg, hash_next;
    logic [WORD_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [WORD_W-1:0] tmp_reg;
    logic [WORD_W-1:0] out_reg;
    logic              out_last_reg;

    logic              not_full;
    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [WORD_W-1:0] wdata;
    logic [CNT_W-1:0]  last_idx;
    logic [7:0]        hbyte;
    logic [WORD_W-1:0] hbase, h1, h2;
    logic [RW-1:0]     r1, r2;
    logic [CNT_W-1:0]  r1m;

    assign not_full = (count_reg < CNT_W'(DEPTH));
    assign last_idx = count_reg - 1'b1;
    assign sts.last_pos = ({{(CNT_W){1'b0}}, idx_reg} == {{(AW){1'b0}}, last_idx});

    // Memory port selection: one write and one read address per cycle.
    always_comb begin
        we    = 1'b0;
        waddr = idx_reg;
        wdata = rdata_reg;
        if (cmd.load_wr && not_full) begin
            we    = 1'b1;
            waddr = count_reg[AW-1:0];
            wdata = in_value;
        end else if (cmd.wr_idx) begin
            we    = 1'b1;
            waddr = idx_reg;
            wdata = rdata_reg;
        end else if (cmd.wr_seed) begin
            we    = 1'b1;
            waddr = seed_reg[AW-1:0];
            wdata = tmp_reg;
        end
        raddr = cmd.rd_seed ? seed_reg[AW-1:0] : idx_reg;
    end

    // Element store with registered read data.
    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[waddr] <= wdata;
        end
        rdata_reg <= store_mem[raddr];
    end

    // One hash round per byte; the first round starts from zero.
    always_comb begin
        hbyte = seed_reg[{cmd.byte_sel, 3'b000} +: 8];
        hbase = (cmd.byte_sel == 2'd0) ? '0 : hash_reg;
        h1    = hbase + {{(WORD_W - 8){1'b0}}, hbyte};
        h2    = h1 + (h1 << 10);
    end

    always_comb begin
        case (cmd.hop)
            HOP_BYTE: hash_next = h2 ^ (h2 >> 6);
            HOP_FIN0: hash_next = hash_reg + (hash_reg << 3);
            HOP_FIN1: hash_next = hash_reg ^ (hash_reg >> 11);
            HOP_FIN2: hash_next = hash_reg + (hash_reg << 15);
            default:  hash_next = hash_reg;
        endcase
    end

    // Restoring modulo by the element count, two dividend bits per step.
    always_comb begin
        r1 = {rem_reg, div_reg[WORD_W-1]};
        if (r1 >= {1'b0, count_reg}) begin
            r1 = r1 - {1'b0, count_reg};
        end
        r1m = r1[CNT_W-1:0];
        r2  = {r1m, div_reg[WORD_W-2]};
        if (r2 >= {1'b0, count_reg}) begin
            r2 = r2 - {1'b0, count_reg};
        end
        div_next = div_reg;
        rem_next = rem_reg;
        if (cmd.div_start) begin
            div_next = hash_reg;
            rem_next = '0;
        end else if (cmd.div_step) begin
            div_next = div_reg << 2;
            rem_next = r2[CNT_W-1:0];
        end
    end

    // Count, position and seed updates.
    always_comb begin
        count_next = count_reg;
        if (cmd.count_clr) begin
            count_next = '0;
        end else if (cmd.load_wr && not_full) begin
            count_next = count_reg + 1'b1;
        end
        idx_next = idx_reg;
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + 1'b1;
        end
        seed_next = seed_reg;
        if (cmd.seed_init) begin
            seed_next = WORD_W'(count_reg) - 1'b1;
        end else if (cmd.seed_from_rem) begin
            seed_next = WORD_W'(rem_reg);
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            seed_reg  <= '0;
            idx_reg   <= '0;
        end else begin
            count_reg <= count_next;
            seed_reg  <= seed_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        hash_reg <= hash_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        if (cmd.tmp_load) begin
            tmp_reg <= rdata_reg;
        end
        if (cmd.out_load) begin
            out_reg      <= rdata_reg;
            out_last_reg <= sts.last_pos;
        end
    end

    assign out_value = out_reg;
    assign out_last  = out_last_reg;

endmodule

// File: rtl/hash_driven_array_shuffle.sv
// Hash-driven array shuffle.
// Words arrive on the s_ stream, one signed 32-bit element per word, and are
// collected until a word with s_tlast high. Once DEPTH elements are held,
// further values are dropped, but a word with s_tlast still ends the set.
// The set is then permuted in place: a seed starts at count minus one, and
// for each position the seed becomes the one-at-a-time hash of its bytes
// modulo the count, and that element is swapped with the current one.
// The shuffled elements leave on the m_ stream in order, the final one with
// m_tlast high; the block then accepts a new set.
// Loading holds s_tready high, so the sender is never stalled. For each
// element the shuffle runs the byte-serial hash, its final mixing, the
// modulo unit (two quotient bits per cycle) and a swap over the single write
// port of the element store. Emission reads and registers each word before
// offering it, and reads the next only after it is taken; a stalled receiver
// simply holds m_tvalid and m_tdata until the word is taken. No input is
// accepted during shuffle and emission. Reset clears the count, the seed,
// the position and the controller; the element store is not cleared.
module hash_driven_array_shuffle
    import hdas_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tlast,   // last_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] value_out
    output logic        m_tlast    // last_out
);

    cmd_t cmd;
    sts_t sts;

    hdas_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hdas_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_value  (s_tdata),
        .sts       (sts),
        .out_value (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// File: tb/tb_hash_driven_array_shuffle.sv
`default_nettype none

module tb_hash_driven_array_shuffle;
    import hdas_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STORE_DEPTH = 64;
    localparam int unsigned TARGET_WORDS = 330;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 100;

    // One element word with its end-of-set flag, used on both streams.
    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              last;
    } set_word_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [WORD_W-1:0] s_tdata = '0;  // [31:0] value
    logic              s_tlast = 1'b0;  // last_in
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [WORD_W-1:0] m_tdata;  // [31:0] value_out
    logic              m_tlast;  // last_out

    // Words waiting to be sent, and shuffled words still owed by the block.
    set_word_t         pending_words[$];
    set_word_t         shuffled_q[$];
    set_word_t         next_word;
    set_word_t         owed_word;

    // Predictor state: the elements of the set being collected and the seed.
    logic [WORD_W-1:0] held_words[STORE_DEPTH];
    int unsigned       held_count = 0;
    logic [WORD_W-1:0] shuffle_seed = '0;

    int unsigned       plan_size = 0;
    int unsigned       words_taken = 0;
    int unsigned       mismatches = 0;
    int unsigned       cycle_count = 0;

    hash_driven_array_shuffle #(
        .DEPTH(STORE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // One-at-a-time hash over the four bytes of a word, lowest byte first.
    function automatic logic [WORD_W-1:0] oaat_mix(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] h;
        h = '0;
        for (int k = 0; k < 4; k++) begin
            h = h + {24'd0, w[8*k +: 8]};
            h = h + (h << 10);
            h = h ^ (h >> 6);
        end
        h = h + (h << 3);
        h = h ^ (h >> 11);
        h = h + (h << 15);
        return h;
    endfunction

    // Collect an accepted word; on the end of a set, shuffle and queue the result.
    task automatic absorb_word(input logic [WORD_W-1:0] v, input logic lst);
        logic [WORD_W-1:0] n;
        logic [WORD_W-1:0] swap;
        set_word_t         w;
        if (held_count < STORE_DEPTH) begin
            held_words[held_count] = v;
            held_count++;
        end
        if (lst && held_count != 0) begin
            n = held_count;
            shuffle_seed = n - 1;
            for (int unsigned i = 0; i < held_count; i++) begin
                shuffle_seed = oaat_mix(shuffle_seed) % n;
                swap = held_words[i];
                held_words[i] = held_words[shuffle_seed];
                held_words[shuffle_seed] = swap;
            end
            for (int unsigned i = 0; i < held_count; i++) begin
                w.value = held_words[i];
                w.last = (i + 1 == held_count);
                shuffled_q.push_back(w);
            end
            held_count = 0;
        end
    endtask

    // Idle percentages: sender light and receiver heavy, then swapped, then none.
    function automatic int unsigned idle_pct(input bit receiver);
        if (words_taken < plan_size / 3) begin
            return receiver ? 74 : 32;
        end else if (words_taken < 2 * plan_size / 3) begin
            return receiver ? 32 : 74;
        end
        return 0;
    endfunction

    // Random element value, leaning on the extremes now and then.
    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: begin
                return 32'h8000_0000;
            end
            1: begin
                return 32'h7FFF_FFFF;
            end
            2: begin
                return 32'hFFFF_FFFF;
            end
            3: begin
                return 32'h0000_0000;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic queue_set(input int unsigned n);
        set_word_t w;
        for (int unsigned i = 0; i < n; i++) begin
            w.value = pick_value();
            w.last = (i + 1 == n);
            pending_words.push_back(w);
        end
    endtask

    task automatic queue_word(input logic [WORD_W-1:0] v, input logic lst);
        set_word_t w;
        w.value = v;
        w.last = lst;
        pending_words.push_back(w);
    endtask

    // Driver: offers the next pending word, holding it until it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                absorb_word(s_tdata, s_tlast);
                words_taken <= words_taken + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
                    next_word = pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_word.value;
                    s_tlast <= next_word.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
        end
    end

    // Monitor: each shuffled word must match the oldest one owed.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (shuffled_q.size() == 0) begin
                $display("%0t: unexpected word, got value %h last %b", $realtime, m_tdata,
                         m_tlast);
                mismatches <= mismatches + 1;
            end else begin
                owed_word = shuffled_q.pop_front();
                if (m_tdata !== owed_word.value || m_tlast !== owed_word.last) begin
                    $display("%0t: mismatch, expected value %h last %b, got value %h last %b",
                             $realtime, owed_word.value, owed_word.last, m_tdata, m_tlast);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words still owed", $realtime, shuffled_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int unsigned r;
        // A single element, a pair, a triple and a set of four, of extreme and alternating values.
        queue_word(32'h8000_0000, 1'b1);
        queue_word(32'h7FFF_FFFF, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b1);
        queue_word(32'h0000_0000, 1'b0);
        queue_word(32'hAAAA_AAAA, 1'b0);
        queue_word(32'h5555_5555, 1'b1);
        queue_word(32'h0000_0001, 1'b0);
        queue_word(32'hFFFF_FFFE, 1'b0);
        queue_word(32'h1234_5678, 1'b0);
        queue_word(32'h8765_4321, 1'b1);
        // A store filled exactly, then one overrun so the tail and the last value drop.
        queue_set(STORE_DEPTH);
        queue_set(STORE_DEPTH + 3);
        // Random sets, mostly short, now and then near or beyond the store size.
        while (pending_words.size() < TARGET_WORDS) begin
            r = $urandom_range(0, 19);
            if (r < 14) begin
                queue_set($urandom_range(1, 8));
            end else if (r < 18) begin
                queue_set($urandom_range(9, 40));
            end else begin
                queue_set($urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 6));
            end
        end
        plan_size = pending_words.size();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for all words to be taken and every shuffled word to come back.
        while (pending_words.size() != 0 || s_tvalid || shuffled_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0 && shuffled_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
rtl/hdas_pkg.sv
rtl/hdas_ctrl.sv
rtl/hdas_dp.sv
rtl/hash_driven_array_shuffle.sv
tb/tb_hash_driven_array_shuffle.sv
